// File: rtl/teb_pkg.sv
// Package for the trigger envelope bank: state, phase and command types,
// fixed-point constants and the clamp helper. Depends on nothing.
`default_nettype none
package teb_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_DEL   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QLOAD, S_DIV, S_MUL, S_POST, S_ACC, S_QFIN,
        S_DRD, S_DLOAD, S_DPICK, S_DSCHK, S_DSRD, S_DSWR, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        PH_F, PH_P, PH_CX, PH_CX2, PH_H1, PH_M2, PH_H2, PH_M3, PH_H3, PH_M4
    } t_phase;

    localparam logic [2:0]  CURVE_COS   = 3'd1;
    localparam logic [2:0]  CURVE_POW_LO = 3'd2;
    localparam logic [2:0]  CURVE_POW_HI = 3'd5;

    localparam int          VAL_BITS  = 18;   // quotient, multiplier A
    localparam int          MB_BITS   = 17;   // multiplier B
    localparam int          PROD_BITS = VAL_BITS + MB_BITS;

    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [16:0] COS_SCALE    = 17'd101581;
    localparam logic [15:0] ACTIVE_LIMIT = 16'd327;
    localparam logic [15:0] LEVEL_MAX    = 16'd32768;
    localparam logic [4:0]  F_STEPS      = 5'd16;

    // Constant divisions of the cosine series: x/56 as (x>>3)/7, x/30 as
    // (x>>1)/15 and x/12 as (x>>2)/3, each by a rounded-up reciprocal that is
    // exact over the operand range.
    localparam int          PRE_H1    = 3;
    localparam int          PRE_H2    = 1;
    localparam int          PRE_H3    = 2;
    localparam logic [17:0] RCP_H1    = 18'd74899;    // 2^19 / 7
    localparam logic [17:0] RCP_H2    = 18'd139811;   // 2^21 / 15
    localparam logic [17:0] RCP_H3    = 18'd174763;   // 2^19 / 3
    localparam int          RSH_SHORT = 19;
    localparam int          RSH_LONG  = 21;

    // 1.0 - y, clamped at zero, in Q1.16.
    function automatic logic [16:0] one_minus(input logic [VAL_BITS-1:0] y);
        logic [VAL_BITS-1:0] d;
        d = VAL_BITS'(ONE_Q16) - y;
        if (y > VAL_BITS'(ONE_Q16)) begin
            return 17'd0;
        end
        return d[16:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/teb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module teb_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/trigger_envelope_bank.sv
// Trigger envelope bank top level: command sequencer, shared divider and
// multiplier, and the envelope table. Depends on teb_pkg and teb_ram.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one command transaction:
//   add an envelope, query the summed level at a tick, delete the next
//   envelope at or after a tick, or clear the table. Output channel
//   (o_valid / i_stall) returns exactly one result transaction per command.
//   o_stall is high while a command is in work; a new transaction is taken
//   only in idle.
//   Delete scans the table entry by entry and then compacts it, moving each
//   later entry down by one. A query reads each envelope in turn; a live one
//   runs 16 divider steps for the phase, then one multiply per power step
//   (eight for the cosine series) before its level is added to the sum.
//   All arithmetic runs through one restoring divider (one bit per cycle)
//   and one registered 18x17 multiplier; the constant divisions of the
//   cosine series are reciprocal multiplies.
//   A finished result waits in the output register while the receiver
//   stalls; the sequencer holds in its final state until the register frees.
//   Reset empties the table and clears the change-tracking state; no
//   clearing pass is needed since only entries below the count are read.
`default_nettype none
module trigger_envelope_bank #(
    parameter int MAX_ENTRIES = 16,
    parameter int TIME_BITS   = 31
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_command,
    input  wire logic [TIME_BITS-1:0] i_time_req,
    input  wire logic [TIME_BITS-1:0] i_start_time,
    input  wire logic [TIME_BITS-1:0] i_end_time,
    input  wire logic [2:0]           i_curve,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [15:0]               o_level,
    output logic                      o_changed,
    output logic [1:0]                o_status
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TB = TIME_BITS;
    localparam int EW = 2 * TIME_BITS + 3;
    localparam int VB = teb_pkg::VAL_BITS;
    localparam int MB = teb_pkg::MB_BITS;
    localparam int PB = teb_pkg::PROD_BITS;

    teb_pkg::t_state r_state, n_state;
    teb_pkg::t_phase r_phase, n_phase;

    logic [TB-1:0] r_t, n_t;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_victim, n_victim;
    logic          r_hit, n_hit;
    logic [TB-1:0] r_best, n_best;
    logic [15:0]   r_sum, n_sum;
    logic [IW-1:0] r_found, n_found;
    logic          r_any, n_any;
    logic [IW-1:0] r_last, n_last;
    logic          r_changed, n_changed;
    logic [2:0]    r_curve, n_curve;
    logic [16:0]   r_q, n_q;
    logic [VB-1:0] r_x2, n_x2;
    logic [VB-1:0] r_ma, n_ma;
    logic [MB-1:0] r_mb, n_mb;
    logic [PB-1:0] r_prod;
    logic [TB-1:0] r_rem, n_rem;
    logic [TB-1:0] r_dsr, n_dsr;
    logic [VB-1:0] r_quo, n_quo;
    logic [4:0]    r_dcnt, n_dcnt;
    logic [2:0]    r_pcnt, n_pcnt;
    logic [15:0]   r_val, n_val;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_level, n_level;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_o_level;
    logic          r_o_changed;
    logic [1:0]    r_o_status;

    logic          in_acc, out_free;
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [TB-1:0] rd_start, rd_end;
    logic [2:0]    rd_curve;
    logic [CW-1:0] idx1;
    logic          more;
    logic          live;
    logic [15:0]   f_w;
    logic [16:0]   q_w;
    logic [VB-1:0] prod_hi;
    logic [VB-1:0] rcp_q;
    logic          is_cos, is_pow, pow_done;
    logic [TB:0]   rem2, sub2;
    logic          ge;
    logic [16:0]   acc_tmp;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != teb_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_level  = r_o_level;
    assign o_changed = r_o_changed;
    assign o_status = r_o_status;

    assign rd_start = ram_rdata[EW-1 -: TB];
    assign rd_end   = ram_rdata[3 +: TB];
    assign rd_curve = ram_rdata[2:0];
    assign idx1     = r_idx + CW'(1);
    assign more     = (idx1 < r_count);
    assign live     = (r_t >= rd_start) && (r_t < rd_end);
    assign f_w      = r_quo[15:0];
    assign q_w      = teb_pkg::ONE_Q16 - {1'b0, f_w};
    assign prod_hi  = r_prod[16 +: VB];
    assign is_cos   = (r_curve == teb_pkg::CURVE_COS);
    assign is_pow   = (r_curve >= teb_pkg::CURVE_POW_LO) && (r_curve <= teb_pkg::CURVE_POW_HI);
    assign pow_done = ((r_pcnt + 3'd1) == (r_curve - 3'd1));

    // Quotient of a reciprocal multiply; the middle division uses the longer shift.
    assign rcp_q    = (r_phase == teb_pkg::PH_H2) ? VB'(r_prod >> teb_pkg::RSH_LONG)
                                                  : VB'(r_prod >> teb_pkg::RSH_SHORT);

    // Restoring divider step for the phase: one quotient bit per cycle.
    assign rem2    = {r_rem, 1'b0};
    assign sub2    = rem2 - {1'b0, r_dsr};
    assign ge      = (rem2 >= {1'b0, r_dsr});
    assign acc_tmp = {1'b0, r_sum} + {1'b0, r_val};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            teb_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (teb_pkg::t_cmd'(i_command))
                        teb_pkg::CMD_QUERY:
                            n_state = (r_count == '0) ? teb_pkg::S_QFIN : teb_pkg::S_QRD;
                        teb_pkg::CMD_DEL:
                            n_state = (r_count == '0) ? teb_pkg::S_DONE : teb_pkg::S_DRD;
                        default: n_state = teb_pkg::S_DONE;
                    endcase
                end
            end
            teb_pkg::S_QRD:   n_state = teb_pkg::S_QLOAD;
            teb_pkg::S_QLOAD: n_state = live ? teb_pkg::S_DIV : teb_pkg::S_ACC;
            teb_pkg::S_DIV:   n_state = (r_dcnt == 5'd1) ? teb_pkg::S_POST : teb_pkg::S_DIV;
            teb_pkg::S_MUL:   n_state = teb_pkg::S_POST;
            teb_pkg::S_POST: begin
                case (r_phase)
                    teb_pkg::PH_F:
                        n_state = (is_cos || is_pow) ? teb_pkg::S_MUL : teb_pkg::S_ACC;
                    teb_pkg::PH_P:
                        n_state = pow_done ? teb_pkg::S_ACC : teb_pkg::S_MUL;
                    teb_pkg::PH_M4: n_state = teb_pkg::S_ACC;
                    default:        n_state = teb_pkg::S_MUL;
                endcase
            end
            teb_pkg::S_ACC:   n_state = more ? teb_pkg::S_QRD : teb_pkg::S_QFIN;
            teb_pkg::S_QFIN:  n_state = teb_pkg::S_DONE;
            teb_pkg::S_DRD:   n_state = teb_pkg::S_DLOAD;
            teb_pkg::S_DLOAD: n_state = more ? teb_pkg::S_DRD : teb_pkg::S_DPICK;
            teb_pkg::S_DPICK: n_state = r_hit ? teb_pkg::S_DSCHK : teb_pkg::S_DONE;
            teb_pkg::S_DSCHK: n_state = more ? teb_pkg::S_DSRD : teb_pkg::S_DONE;
            teb_pkg::S_DSRD:  n_state = teb_pkg::S_DSWR;
            teb_pkg::S_DSWR:  n_state = teb_pkg::S_DSCHK;
            teb_pkg::S_DONE:  n_state = out_free ? teb_pkg::S_IDLE : teb_pkg::S_DONE;
            default:          n_state = teb_pkg::S_IDLE;
        endcase
    end

    // RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[IW-1:0];
        case (r_state)
            teb_pkg::S_IDLE: begin
                ram_waddr = r_count[IW-1:0];
                ram_wdata = {i_start_time, i_end_time, i_curve};
                ram_we    = in_acc && (i_command == teb_pkg::CMD_ADD)
                            && (r_count < CW'(MAX_ENTRIES));
            end
            teb_pkg::S_DSRD: ram_raddr = idx1[IW-1:0];
            teb_pkg::S_DSWR: ram_we    = 1'b1;
            default: ram_we = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_phase = r_phase;   n_t = r_t;
        n_count = r_count;   n_idx = r_idx;       n_victim = r_victim;
        n_hit = r_hit;       n_best = r_best;     n_sum = r_sum;
        n_found = r_found;   n_any = r_any;       n_last = r_last;
        n_changed = r_changed; n_curve = r_curve; n_q = r_q;
        n_x2 = r_x2;         n_ma = r_ma;         n_mb = r_mb;
        n_rem = r_rem;       n_dsr = r_dsr;
        n_quo = r_quo;       n_dcnt = r_dcnt;     n_pcnt = r_pcnt;
        n_val = r_val;       n_status = r_status; n_level = r_level;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            teb_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_t      = i_time_req;
                    n_status = teb_pkg::ST_OK;
                    n_level  = '0;
                    n_idx    = '0;
                    n_sum    = '0;
                    n_any    = 1'b0;
                    n_found  = '0;
                    n_hit    = 1'b0;
                    case (teb_pkg::t_cmd'(i_command))
                        teb_pkg::CMD_ADD: begin
                            if (r_count < CW'(MAX_ENTRIES)) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_status = teb_pkg::ST_FULL;
                            end
                        end
                        teb_pkg::CMD_DEL: begin
                            if (r_count == '0) begin
                                n_status = teb_pkg::ST_NONE;
                            end
                        end
                        teb_pkg::CMD_CLEAR: n_count = '0;
                        default: n_count = r_count;
                    endcase
                end
            end
            teb_pkg::S_QLOAD: begin
                n_val   = '0;
                n_curve = rd_curve;
                n_rem   = r_t - rd_start;
                n_dsr   = rd_end - rd_start;
                n_quo   = '0;
                n_dcnt  = teb_pkg::F_STEPS;
                n_phase = teb_pkg::PH_F;
            end
            teb_pkg::S_DIV: begin
                n_rem  = ge ? sub2[TB-1:0] : rem2[TB-1:0];
                n_quo  = {r_quo[VB-2:0], ge};
                n_dcnt = r_dcnt - 5'd1;
            end
            teb_pkg::S_POST: begin
                case (r_phase)
                    teb_pkg::PH_F: begin
                        n_q = q_w;
                        if (is_cos) begin
                            n_ma    = {{(VB-16){1'b0}}, f_w};
                            n_mb    = teb_pkg::COS_SCALE;
                            n_phase = teb_pkg::PH_CX;
                        end else if (is_pow) begin
                            n_ma    = {{(VB-17){1'b0}}, q_w};
                            n_mb    = q_w;
                            n_pcnt  = '0;
                            n_phase = teb_pkg::PH_P;
                        end else begin
                            n_val = q_w[16:1];
                        end
                    end
                    teb_pkg::PH_P: begin
                        n_val  = prod_hi[16:1];
                        n_ma   = prod_hi;
                        n_mb   = r_q;
                        n_pcnt = r_pcnt + 3'd1;
                    end
                    teb_pkg::PH_CX: begin
                        n_ma    = prod_hi;
                        n_mb    = prod_hi[MB-1:0];
                        n_phase = teb_pkg::PH_CX2;
                    end
                    teb_pkg::PH_CX2: begin
                        n_x2    = prod_hi;
                        n_ma    = teb_pkg::RCP_H1;
                        n_mb    = MB'(prod_hi >> teb_pkg::PRE_H1);
                        n_phase = teb_pkg::PH_H1;
                    end
                    teb_pkg::PH_H1: begin
                        n_ma    = r_x2;
                        n_mb    = teb_pkg::one_minus(rcp_q);
                        n_phase = teb_pkg::PH_M2;
                    end
                    teb_pkg::PH_M2: begin
                        n_ma    = teb_pkg::RCP_H2;
                        n_mb    = MB'(prod_hi >> teb_pkg::PRE_H2);
                        n_phase = teb_pkg::PH_H2;
                    end
                    teb_pkg::PH_H2: begin
                        n_ma    = r_x2;
                        n_mb    = teb_pkg::one_minus(rcp_q);
                        n_phase = teb_pkg::PH_M3;
                    end
                    teb_pkg::PH_M3: begin
                        n_ma    = teb_pkg::RCP_H3;
                        n_mb    = MB'(prod_hi >> teb_pkg::PRE_H3);
                        n_phase = teb_pkg::PH_H3;
                    end
                    teb_pkg::PH_H3: begin
                        n_ma    = r_x2;
                        n_mb    = teb_pkg::one_minus(rcp_q);
                        n_phase = teb_pkg::PH_M4;
                    end
                    default: begin
                        n_val = 16'(teb_pkg::one_minus({1'b0, prod_hi[VB-1:1]}) >> 1);
                    end
                endcase
            end
            teb_pkg::S_ACC: begin
                // Saturate as we go; the terms are never negative.
                n_sum = (acc_tmp > {1'b0, teb_pkg::LEVEL_MAX}) ? teb_pkg::LEVEL_MAX
                                                               : acc_tmp[15:0];
                if (r_val > teb_pkg::ACTIVE_LIMIT) begin
                    n_found = r_idx[IW-1:0];
                    n_any   = 1'b1;
                end
                n_idx = idx1;
            end
            teb_pkg::S_QFIN: begin
                n_level   = r_sum;
                n_changed = 1'b0;
                if (r_any && (r_found != r_last)) begin
                    n_changed = 1'b1;
                    n_last    = r_found;
                end
            end
            teb_pkg::S_DLOAD: begin
                if ((r_t <= rd_start) && (!r_hit || (rd_start <= r_best))) begin
                    n_hit    = 1'b1;
                    n_victim = r_idx[IW-1:0];
                    n_best   = rd_start;
                end
                n_idx = idx1;
            end
            teb_pkg::S_DPICK: begin
                n_idx = CW'(r_victim);
                if (!r_hit) begin
                    n_status = teb_pkg::ST_NONE;
                end
            end
            teb_pkg::S_DSCHK: begin
                if (!more) begin
                    n_count = r_count - CW'(1);
                end
            end
            teb_pkg::S_DSWR: n_idx = idx1;
            default: n_idx = r_idx;
        endcase
        if ((r_state == teb_pkg::S_DONE) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= teb_pkg::S_IDLE;
            r_count     <= '0;
            r_last      <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;   r_t <= n_t;
        r_idx <= n_idx;       r_victim <= n_victim; r_hit <= n_hit;
        r_best <= n_best;     r_sum <= n_sum;       r_found <= n_found;
        r_any <= n_any;       r_curve <= n_curve;   r_q <= n_q;
        r_x2 <= n_x2;         r_ma <= n_ma;         r_mb <= n_mb;
        r_rem <= n_rem;       r_dsr <= n_dsr;
        r_quo <= n_quo;       r_dcnt <= n_dcnt;     r_pcnt <= n_pcnt;
        r_val <= n_val;       r_status <= n_status; r_level <= n_level;
        // Shared multiplier, registered.
        r_prod <= {{MB{1'b0}}, r_ma} * {{VB{1'b0}}, r_mb};
        if ((r_state == teb_pkg::S_DONE) && out_free) begin
            r_o_level   <= r_level;
            r_o_changed <= r_changed;
            r_o_status  <= r_status;
        end
    end

    teb_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_level_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= teb_pkg::LEVEL_MAX))
        else $error("level above saturation");

    a_status_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != teb_pkg::ST_OK)) |-> (o_level == '0))
        else $error("failed command with nonzero level");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == teb_pkg::S_IDLE) || (r_state == teb_pkg::S_DSWR)))
        else $error("table write outside add or compaction");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == teb_pkg::S_DIV) |-> (r_dcnt != 5'd0))
        else $error("divider running with no steps left");

endmodule
`default_nettype wire

// File: tb/sv/tb_trigger_envelope_bank.sv
// Self-checking testbench for trigger_envelope_bank: directed and random command
// traffic, a bit-accurate envelope predictor and an in-order result check.
// Depends on teb_pkg and the trigger_envelope_bank RTL.
`default_nettype none

// Result of one command as the block should report it.
typedef struct packed {
    logic [15:0] level;
    logic        changed;
    logic [1:0]  status;
} envelope_result_t;

class envelope_scoreboard;
    localparam int DEPTH = 16;

    // Predicted table and change-tracking state.
    bit [4:0]  count;
    bit [30:0] tbl_start [DEPTH];
    bit [30:0] tbl_end   [DEPTH];
    bit [2:0]  tbl_curve [DEPTH];
    bit [3:0]  last_index;
    bit        changed_flag;

    envelope_result_t pending_results[$];
    int errors;

    function new();
        count = 0;
        last_index = 0;
        changed_flag = 0;
        errors = 0;
    endfunction

    static function longint clamp_unit(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return v;
    endfunction

    // Level of one stored envelope at tick t, zero when it is not live.
    function longint envelope_level(int k, longint t);
        longint s, e, f, q, p, x, x2, h;
        s = tbl_start[k];
        e = tbl_end[k];
        if (t < s || t >= e) return 0;
        f = ((t - s) << 16) / (e - s);
        q = 65536 - f;
        if (tbl_curve[k] == teb_pkg::CURVE_COS) begin
            x  = (f * 101581) >>> 16;
            x2 = (x * x) >>> 16;
            h  = clamp_unit(65536 - x2 / 56);
            h  = clamp_unit(65536 - ((x2 * h) >>> 16) / 30);
            h  = clamp_unit(65536 - ((x2 * h) >>> 16) / 12);
            h  = clamp_unit(65536 - (((x2 * h) >>> 16) >>> 1));
            return h >>> 1;
        end
        if (tbl_curve[k] >= teb_pkg::CURVE_POW_LO && tbl_curve[k] <= teb_pkg::CURVE_POW_HI) begin
            p = q;
            for (int n = 1; n < tbl_curve[k]; n++) p = (p * q) >>> 16;
            return p >>> 1;
        end
        return q >>> 1;
    endfunction

    // Advance the predicted state by one accepted command and queue its result.
    function void note_command(teb_pkg::t_cmd cmd, bit [30:0] t, bit [30:0] st,
                               bit [30:0] en, bit [2:0] cv);
        envelope_result_t r;
        longint sum, v;
        bit any, hit;
        int found, victim;
        bit [30:0] best;
        r = '0;
        r.status = teb_pkg::ST_OK;
        case (cmd)
            teb_pkg::CMD_ADD: begin
                if (count >= DEPTH) begin
                    r.status = teb_pkg::ST_FULL;
                end else begin
                    tbl_start[count] = st;
                    tbl_end[count]   = en;
                    tbl_curve[count] = cv;
                    count++;
                end
            end
            teb_pkg::CMD_QUERY: begin
                sum = 0;
                any = 0;
                found = 0;
                for (int k = 0; k < count; k++) begin
                    v = envelope_level(k, t);
                    if (v > 327) begin
                        found = k;
                        any = 1;
                    end
                    sum += v;
                end
                r.level = (sum > 32768) ? 16'd32768 : sum[15:0];
                changed_flag = 0;
                if (any && found[3:0] != last_index) begin
                    changed_flag = 1;
                    last_index = found[3:0];
                end
            end
            teb_pkg::CMD_DEL: begin
                hit = 0;
                victim = 0;
                best = 0;
                // Smallest start at or after t; ties go to the later entry.
                for (int k = 0; k < count; k++) begin
                    if (t <= tbl_start[k] && (!hit || tbl_start[k] <= best)) begin
                        hit = 1;
                        victim = k;
                        best = tbl_start[k];
                    end
                end
                if (!hit) begin
                    r.status = teb_pkg::ST_NONE;
                end else begin
                    for (int k = victim; k + 1 < count; k++) begin
                        tbl_start[k] = tbl_start[k + 1];
                        tbl_end[k]   = tbl_end[k + 1];
                        tbl_curve[k] = tbl_curve[k + 1];
                    end
                    count--;
                end
            end
            default: count = 0;
        endcase
        r.changed = changed_flag;
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] level, logic changed, logic [1:0] status);
        envelope_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result level=%0d changed=%0d status=%0d",
                     $realtime, level, changed, status);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (level !== want.level) begin
            $display("%0t: level expected %0d actual %0d", $realtime, want.level, level);
            errors++;
        end
        if (changed !== want.changed) begin
            $display("%0t: changed expected %0d actual %0d", $realtime, want.changed, changed);
            errors++;
        end
        if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, status);
            errors++;
        end
    endfunction
endclass

module tb_trigger_envelope_bank;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 900;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam bit [30:0] TMAX = 31'h7fff_ffff;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_command = '0;
    logic [30:0] i_time_req = '0;
    logic [30:0] i_start_time = '0;
    logic [30:0] i_end_time = '0;
    logic [2:0]  i_curve = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_level;
    logic        o_changed;
    logic [1:0]  o_status;

    envelope_scoreboard sb = new();
    longint cycles = 0;
    int     burst_left = 0;
    int     stall_mode = 0;

    trigger_envelope_bank uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_time_req(i_time_req),
        .i_start_time(i_start_time), .i_end_time(i_end_time), .i_curve(i_curve),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_level(o_level), .o_changed(o_changed), .o_status(o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check accepted results and drive the receiver stall. The stall style
    // is picked at random among none, light, heavy and long stretches.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_trigger_envelope_bank: errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_level, o_changed, o_status);
        end
        if (cycles % 300 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (cycles % 64) < 40;
        endcase
    end

    // Present one command and hold it until the block takes it. Bursts of
    // back-to-back transactions are separated by random gaps.
    task automatic send_command(teb_pkg::t_cmd cmd, bit [30:0] t, bit [30:0] st,
                                bit [30:0] en, bit [2:0] cv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_time_req   <= t;
        i_start_time <= st;
        i_end_time   <= en;
        i_curve      <= cv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(cmd, t, st, en, cv);
    endtask

    // Mostly nearby ticks so envelopes overlap and queries land inside them;
    // now and then a full-width value to reach every time bit.
    function automatic bit [30:0] pick_tick(int span);
        if ($urandom_range(0, 15) == 0) return 31'($urandom() & TMAX);
        return 31'($urandom_range(0, span));
    endfunction

    task automatic send_random();
        int sel;
        bit [30:0] st, en;
        teb_pkg::t_cmd cmd;
        sel = $urandom_range(0, 99);
        st = pick_tick(4000);
        case ($urandom_range(0, 9))
            0: en = st;                                  // empty span
            1: en = pick_tick(4000);                     // possibly reversed
            2: en = (st > TMAX - 40) ? TMAX : 31'(st + $urandom_range(1, 40));
            default: en = (st > TMAX - 3000) ? TMAX : 31'(st + $urandom_range(1, 3000));
        endcase
        if (sel < 36)      cmd = teb_pkg::CMD_ADD;
        else if (sel < 78) cmd = teb_pkg::CMD_QUERY;
        else if (sel < 97) cmd = teb_pkg::CMD_DEL;
        else               cmd = teb_pkg::CMD_CLEAR;
        send_command(cmd, pick_tick(7000), st, en, 3'($urandom_range(0, 7)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one full-range envelope per curve code, then queries at
        // the span edges and the middle, so every curve is summed and saturated.
        for (int c = 0; c < 8; c++) begin
            send_command(teb_pkg::CMD_ADD, '0, '0, TMAX, c[2:0]);
        end
        send_command(teb_pkg::CMD_QUERY, '0, TMAX, '0, 3'd7);
        send_command(teb_pkg::CMD_QUERY, 31'h4000_0000, '0, '0, '0);
        send_command(teb_pkg::CMD_QUERY, TMAX - 31'd1, '0, '0, '0);
        send_command(teb_pkg::CMD_QUERY, TMAX, '0, '0, '0);
        // Empty and reversed spans, a same-start pair for the delete tie,
        // then fill the table and try one more add.
        send_command(teb_pkg::CMD_ADD, '0, 31'd500, 31'd500, 3'd1);
        send_command(teb_pkg::CMD_ADD, '0, TMAX, 31'd0, 3'd2);
        send_command(teb_pkg::CMD_ADD, '0, 31'd100, 31'd900, 3'd3);
        send_command(teb_pkg::CMD_ADD, '0, 31'd100, 31'd300, 3'd4);
        for (int k = 0; k < 5; k++) begin
            send_command(teb_pkg::CMD_ADD, '0, 31'd1000, 31'd2000, 3'd5);
        end
        send_command(teb_pkg::CMD_QUERY, 31'd150, '0, '0, '0);
        send_command(teb_pkg::CMD_DEL, 31'd50, '0, '0, '0);
        send_command(teb_pkg::CMD_DEL, TMAX, '0, '0, '0);
        send_command(teb_pkg::CMD_CLEAR, '0, '0, '0, '0);
        send_command(teb_pkg::CMD_DEL, '0, '0, '0, '0);
        send_command(teb_pkg::CMD_QUERY, 31'd150, '0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random();
        end
        i_valid <= 1'b0;

        // Drain, then hold a little longer to catch any stray result.
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_trigger_envelope_bank: clean");
        end else begin
            $display("tb_trigger_envelope_bank: errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
